>>> hdl/half_single_float_converter_assert.svh
// Assertion macros for the half/single float converter.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef HALF_SINGLE_FLOAT_CONVERTER_ASSERT_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define HSFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define HSFC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> hdl/hsfc_pkg.sv
// Shared types and constants for the half/single float converter.
// No dependencies.
package hsfc_pkg;

    localparam int DATA_W   = 32;
    localparam int HALF_W   = 16;

    typedef enum logic {
        OP_S2H = 1'b0,
        OP_H2S = 1'b1
    } op_t;

    localparam logic [14:0] HALF_INF_MAG  = 15'h7C00;
    localparam logic [15:0] HALF_NAN      = 16'hFE00;
    localparam logic [7:0]  SGL_EXP_ONES  = 8'hFF;
    localparam logic [4:0]  HALF_EXP_ONES = 5'h1F;
    localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
    localparam logic [7:0]  EXP_OVF_MIN   = 8'd143;
    localparam logic [7:0]  EXP_SUB_MIN   = 8'd102;
    localparam logic [7:0]  SUB_SHIFT_M1  = 8'd125;

endpackage

>>> hdl/hsfc_s2h.sv
// Single to half conversion datapath, combinational.
// Depends on hsfc_pkg.
module hsfc_s2h
    import hsfc_pkg::*;
(
    input  logic [DATA_W-1:0] single_bits,
    output logic [HALF_W-1:0] half_bits
);

    logic        sgn;
    logic [7:0]  xe;
    logic [22:0] xm;
    logic [23:0] full;
    logic [7:0]  sh_m1_full;
    logic [23:0] shifted;
    logic [10:0] mag;
    logic [7:0]  hexp_full;
    logic [15:0] norm;

    always_comb
    begin
        sgn        = single_bits[31];
        xe         = single_bits[30:23];
        xm         = single_bits[22:0];
        full       = {1'b1, xm};
        sh_m1_full = SUB_SHIFT_M1 - xe;
        shifted    = full >> sh_m1_full[4:0];
        mag        = {1'b0, shifted[10:1]} + {10'b0, shifted[0]};
        hexp_full  = xe - EXP_BIAS_DIFF;
        norm       = {sgn, hexp_full[4:0], xm[22:13]} + {15'b0, xm[12]};

        if (xe == 8'd0)
        begin
            half_bits = {sgn, 15'b0};
        end
        else if (xe == SGL_EXP_ONES)
        begin
            half_bits = (xm == 23'd0) ? {sgn, HALF_INF_MAG} : HALF_NAN;
        end
        else if (xe >= EXP_OVF_MIN)
        begin
            half_bits = {sgn, HALF_INF_MAG};
        end
        else if (xe <= EXP_BIAS_DIFF)
        begin
            half_bits = (xe >= EXP_SUB_MIN) ? {sgn, 4'b0, mag} : {sgn, 15'b0};
        end
        else
        begin
            half_bits = norm;
        end
    end

endmodule

>>> hdl/hsfc_h2s.sv
// Half to single conversion datapath with leading-zero count, combinational.
// Depends on hsfc_pkg.
module hsfc_h2s
    import hsfc_pkg::*;
(
    input  logic [HALF_W-1:0] half_bits,
    output logic [DATA_W-1:0] single_bits
);

    logic        sgn;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  lz;
    logic [10:0] mant_sh;
    logic [7:0]  sub_exp;
    logic [7:0]  norm_exp;

    always_comb
    begin
        sgn = half_bits[15];
        he  = half_bits[14:10];
        hm  = half_bits[9:0];

        lz = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hm[i])
            begin
                lz = 4'(9 - i);
            end
        end

        mant_sh  = {hm, 1'b0} << lz;
        sub_exp  = EXP_BIAS_DIFF - {4'b0, lz};
        norm_exp = {3'b0, he} + EXP_BIAS_DIFF;

        if (half_bits[14:0] == 15'd0)
        begin
            single_bits = {sgn, 31'b0};
        end
        else if (he == 5'd0)
        begin
            single_bits = {sgn, sub_exp, mant_sh[9:0], 13'b0};
        end
        else if (he == HALF_EXP_ONES)
        begin
            single_bits = (hm == 10'd0) ? {sgn, SGL_EXP_ONES, 23'b0} : 32'd0;
        end
        else
        begin
            single_bits = {sgn, norm_exp, hm, 13'b0};
        end
    end

endmodule

>>> hdl/half_single_float_converter.sv
// Half/single float converter: one operand per beat. Input register,
// combinational conversion logic, result register; one beat per cycle
// sustained throughput while result_ready is high. The input register can
// take a new beat while an earlier result waits in the result register.
// Reset clears both valid flags; no sweep.
// Depends on hsfc_pkg, hsfc_s2h, hsfc_h2s and the assertion header.
`include "half_single_float_converter_assert.svh"

module half_single_float_converter
    import hsfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              opcode,
    input  logic [DATA_W-1:0] operand_bits,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [DATA_W-1:0] result_bits
);

    logic              a_valid_reg, a_valid_next;
    op_t               a_op_reg;
    logic [DATA_W-1:0] a_bits_reg;
    logic              b_valid_reg, b_valid_next;
    logic [DATA_W-1:0] result_reg, result_next;
    logic              b_adv;
    logic              item_accept;
    logic [HALF_W-1:0] s2h_bits;
    logic [DATA_W-1:0] h2s_bits;

    hsfc_s2h u_s2h
    (
        .single_bits (a_bits_reg),
        .half_bits   (s2h_bits)
    );

    hsfc_h2s u_h2s
    (
        .half_bits   (a_bits_reg[HALF_W-1:0]),
        .single_bits (h2s_bits)
    );

    always_comb
    begin
        b_adv        = !b_valid_reg || result_ready;
        item_ready   = !a_valid_reg || b_adv;
        item_accept  = item_valid && item_ready;
        a_valid_next = item_accept ? 1'b1 : (b_adv ? 1'b0 : a_valid_reg);
        b_valid_next = b_adv ? a_valid_reg : b_valid_reg;
        result_next  = (a_op_reg == OP_S2H) ? {{(DATA_W-HALF_W){1'b0}}, s2h_bits} : h2s_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            a_op_reg   <= op_t'(opcode);
            a_bits_reg <= operand_bits;
        end
        if (a_valid_reg && b_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = b_valid_reg;
    assign result_bits  = result_reg;

    `HSFC_ASSERT_NEXT(a_moves_to_b, a_valid_reg && b_adv, b_valid_reg, "staged beat lost")
    `HSFC_ASSERT_NEXT(a_holds, a_valid_reg && !b_adv,
        a_valid_reg && $stable(a_bits_reg), "input stage changed while blocked")
    `HSFC_ASSERT_NEXT(half_upper_zero, a_valid_reg && b_adv && a_op_reg == OP_S2H,
        result_reg[DATA_W-1:HALF_W] == '0, "half result has upper bits set")
    `HSFC_ASSERT_NEXT(half_nan_zero,
        a_valid_reg && b_adv && a_op_reg == OP_H2S && a_bits_reg[14:10] == HALF_EXP_ONES
        && a_bits_reg[9:0] != 10'd0, result_reg == '0, "half NaN not mapped to +0")

endmodule
